[hdl/lmpc_pkg.sv]
// Shared types, constants and fixed-point helpers of the lateral MPC steering solver.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none
package lmpc_pkg;

  // Horizon and iteration bounds.
  localparam int N        = 16;
  localparam int HW       = $clog2(N);
  localparam int KW       = HW + 1;
  localparam int MAX_ITER = 128;
  localparam int ITW      = $clog2(MAX_ITER + 1);

  // Fixed weights and speed limits, Q16.16.
  localparam logic signed [31:0] TERMINAL_LATERAL_WEIGHT = 32'sd6553600;
  localparam logic signed [31:0] TERMINAL_YAW_WEIGHT     = 32'sd1638400;
  localparam logic signed [31:0] SPEED_MAX               = 32'sd131072;
  localparam logic signed [31:0] SPEED_FALLBACK          = 32'sd32768;

  // Solver constants: step size, momentum, speed floor, stop threshold.
  localparam logic signed [31:0] Q_ALPHA          = 32'sd655;
  localparam logic signed [31:0] Q_BETA           = 32'sd58982;
  localparam logic signed [31:0] Q_ONE_MINUS_BETA = 32'sd6554;
  localparam logic signed [31:0] Q_SPEED_FLOOR    = 32'sd6554;
  localparam logic [63:0]        Q_STOP_SQ        = 64'd43;

  // Configuration register indexes.
  localparam logic [2:0] CFG_TIME_STEP     = 3'd0;
  localparam logic [2:0] CFG_INV_WHEELBASE = 3'd1;
  localparam logic [2:0] CFG_LATERAL_W     = 3'd2;
  localparam logic [2:0] CFG_YAW_W         = 3'd3;
  localparam logic [2:0] CFG_EFFORT_W      = 3'd4;
  localparam logic [2:0] CFG_RATE_W        = 3'd5;
  localparam logic [2:0] CFG_STEER_LIMIT   = 3'd6;
  localparam logic [2:0] CFG_RATE_LIMIT    = 3'd7;

  typedef logic signed [31:0] q_t;

  // Operands of the shared multiplier.
  typedef struct packed {
    q_t a;
    q_t b;
  } mul_req_t;

  // Sequencer states.
  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_SETUP  = 14'b00000000000010,
    S_PROP   = 14'b00000000000100,
    S_HSTART = 14'b00000000001000,
    S_HMUL1  = 14'b00000000010000,
    S_HMUL2  = 14'b00000000100000,
    S_HACC   = 14'b00000001000000,
    S_HFIN   = 14'b00000010000000,
    S_GINIT  = 14'b00000100000000,
    S_GRAD   = 14'b00001000000000,
    S_UPD    = 14'b00010000000000,
    S_RATE   = 14'b00100000000000,
    S_NORM   = 14'b01000000000000,
    S_OUT    = 14'b10000000000000
  } state_t;

  // Saturate a 34-bit sum to 32 bits.
  function automatic q_t sat34(input logic signed [33:0] x);
    q_t r;
    if (x > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (x < 34'sh3_8000_0000) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    return sat34(34'(a) + 34'(b));
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    return sat34(34'(a) - 34'(b));
  endfunction

  function automatic q_t qdbl(input q_t a);
    return sat34(34'(a) + 34'(a));
  endfunction

  // Round a raw Q32.32 product to Q16.16 (floor after adding one half) and saturate.
  function automatic q_t qround(input logic signed [63:0] p);
    logic signed [63:0] t;
    q_t r;
    t = (p + 64'sd32768) >>> 16;
    if (t > 64'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (t < -64'sd2147483648) r = 32'sh8000_0000;
    else r = t[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/lmpc_mul.sv]
// Shared 32x32 signed multiplier of the solver with a registered raw product.
// Gives the raw product and its rounded, saturated Q16.16 value; uses lmpc_pkg.
`default_nettype none
module lmpc_mul (
  input  wire logic              clk,
  input  wire lmpc_pkg::mul_req_t req,
  output logic signed [63:0]     prod,
  output lmpc_pkg::q_t           qv
);

  logic signed [63:0] prod_r;

  // One product per cycle, registered.
  always_ff @(posedge clk) begin
    prod_r <= 64'(req.a) * 64'(req.b);
  end

  assign prod = prod_r;
  assign qv   = lmpc_pkg::qround(prod_r);

endmodule
`default_nettype wire

[hdl/lateral_mpc_steering_solver.sv]
// Top level of the lateral MPC steering solver: sequencer, stores and config registers.
// Depends on lmpc_pkg and lmpc_mul.
//
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_ready  | lateral_error, heading_error, speed
// out     | output    | out_valid/out_ready| steering_angle, speed_clipped
// cfg     | input     | cfg_wr_en          | cfg_index, cfg_wdata
//
// One item first builds the QP (each Hessian term passes S_HMUL1, S_HMUL2 and
// S_HACC) and then runs descent iterations, up to 128 of them.
// All of it runs through the single shared multiplier in lmpc_mul.
// Reset is synchronous and active low; no clearing pass is needed.
// in_ready is high only while the sequencer is idle; a finished item waits in the
// output register while the next item may already be taken.
`default_nettype none
module lateral_mpc_steering_solver (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_lateral_error,
  input  wire logic signed [31:0] in_heading_error,
  input  wire logic signed [23:0] in_speed,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [18:0]      out_steering_angle,
  output logic                    out_speed_clipped,
  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [26:0]        cfg_wdata
);

  localparam int N  = lmpc_pkg::N;
  localparam int HW = lmpc_pkg::HW;
  localparam int KW = lmpc_pkg::KW;

  // Configuration registers.
  logic [16:0] ts_r;
  logic [22:0] iw_r;
  logic [26:0] lw_r, yw_r, ew_r, rw_r;
  logic [17:0] sl_r, srl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r  <= 17'd3277;
      iw_r  <= 23'd262144;
      lw_r  <= 27'd1310720;
      yw_r  <= 27'd327680;
      ew_r  <= 27'd65536;
      rw_r  <= 27'd655360;
      sl_r  <= 18'd32768;
      srl_r <= 18'd6554;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lmpc_pkg::CFG_TIME_STEP:     ts_r  <= cfg_wdata[16:0];
        lmpc_pkg::CFG_INV_WHEELBASE: iw_r  <= cfg_wdata[22:0];
        lmpc_pkg::CFG_LATERAL_W:     lw_r  <= cfg_wdata;
        lmpc_pkg::CFG_YAW_W:         yw_r  <= cfg_wdata;
        lmpc_pkg::CFG_EFFORT_W:      ew_r  <= cfg_wdata;
        lmpc_pkg::CFG_RATE_W:        rw_r  <= cfg_wdata;
        lmpc_pkg::CFG_STEER_LIMIT:   sl_r  <= cfg_wdata[17:0];
        lmpc_pkg::CFG_RATE_LIMIT:    srl_r <= cfg_wdata[17:0];
        default: ;
      endcase
    end
  end

  // Registers widened to signed Q16.16.
  lmpc_pkg::q_t ts_q, iw_q, lw_q, yw_q, ew_q, rw_q, sl_q, srl_q, rw2_q;
  assign ts_q  = lmpc_pkg::q_t'({15'd0, ts_r});
  assign iw_q  = lmpc_pkg::q_t'({9'd0, iw_r});
  assign lw_q  = lmpc_pkg::q_t'({5'd0, lw_r});
  assign yw_q  = lmpc_pkg::q_t'({5'd0, yw_r});
  assign ew_q  = lmpc_pkg::q_t'({5'd0, ew_r});
  assign rw_q  = lmpc_pkg::q_t'({5'd0, rw_r});
  assign sl_q  = lmpc_pkg::q_t'({14'd0, sl_r});
  assign srl_q = lmpc_pkg::q_t'({14'd0, srl_r});
  assign rw2_q = lmpc_pkg::qdbl(rw_q);

  // Control state.
  lmpc_pkg::state_t state_r, state_nxt;
  logic [2:0]       ph_r, ph_nxt;
  logic [HW-1:0]    j_r, j_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic [HW-1:0]    i_r, i_nxt;
  logic             odd_r, odd_nxt;
  logic [KW-1:0]    rd_k_r, rd_k_nxt;
  logic [HW-1:0]    k1_r, k1_nxt;
  logic             v1_r, v1_nxt, v2_r, v2_nxt;
  logic [lmpc_pkg::ITW-1:0] it_r, it_nxt;
  logic             out_valid_r, out_valid_nxt;
  lmpc_pkg::q_t     steer_now_r, steer_now_nxt, steer_before_r, steer_before_nxt;

  // Payload registers.
  lmpc_pkg::q_t x0_r, x0_nxt, x1_r, x1_nxt, v_r, v_nxt;
  logic         clip_r, clip_nxt;
  lmpc_pkg::q_t dv_r, dv_nxt, b1_r, b1_nxt, dx_r, dx_nxt, dg_r, dg_nxt, rb_r, rb_nxt;
  lmpc_pkg::q_t flast_r, flast_nxt, glast_r, glast_nxt;
  lmpc_pkg::q_t s_r, s_nxt, t1_r, t1_nxt, d_r, d_nxt, prev_r, prev_nxt;
  logic [63:0]  sum_r, sum_nxt;
  logic signed [18:0] out_steer_r, out_steer_nxt;
  logic         out_clip_r, out_clip_nxt;

  // Small vector stores.
  lmpc_pkg::q_t f0_r [N], f0_nxt [N];
  lmpc_pkg::q_t g_r [N], g_nxt [N];
  lmpc_pkg::q_t lt_r [N], lt_nxt [N];
  lmpc_pkg::q_t mv_r [N], mv_nxt [N];
  lmpc_pkg::q_t last_r [N], last_nxt [N];
  lmpc_pkg::q_t mom_r [N], mom_nxt [N];
  lmpc_pkg::q_t grad_r [N], grad_nxt [N];

  // Hessian memory with registered read.
  lmpc_pkg::q_t hmem [N*N];
  lmpc_pkg::q_t hq_r;
  logic              hw_en, hr_en;
  logic [2*HW-1:0]   hw_addr, hr_addr;
  lmpc_pkg::q_t      hw_data;

  always_ff @(posedge clk) begin
    if (hw_en) hmem[hw_addr] <= hw_data;
    if (hr_en) hq_r <= hmem[hr_addr];
  end

  // Shared multiplier.
  lmpc_pkg::mul_req_t mreq;
  logic signed [63:0] prod;
  lmpc_pkg::q_t       qv;

  lmpc_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (prod),
    .qv   (qv)
  );

  // Operand selection for the QP build.
  logic          lin, last_row, diag, nbr, inner;
  logic [HW-1:0] g_idx, mv_idx;
  lmpc_pkg::q_t  g_rd, mv_rd, w_sel, first_b, second_b;
  lmpc_pkg::q_t  vin, vsel, diff, upd_t, rate_nv;
  logic signed [33:0] adj;

  always_comb begin
    lin      = (k_r == KW'(N));
    last_row = (i_r == HW'(N - 1));
    g_idx    = (state_r == lmpc_pkg::S_HMUL2 && !lin) ? i_r - k_r[HW-1:0] : i_r - j_r;
    g_rd     = g_r[g_idx];
    mv_idx   = (state_r == lmpc_pkg::S_GRAD) ? k1_r : j_r;
    mv_rd    = mv_r[mv_idx];
    if (odd_r) w_sel = last_row ? lmpc_pkg::TERMINAL_YAW_WEIGHT : yw_q;
    else w_sel = last_row ? lmpc_pkg::TERMINAL_LATERAL_WEIGHT : lw_q;
    if (lin) first_b = odd_r ? x1_r : f0_r[i_r];
    else first_b = odd_r ? b1_r : g_rd;
    second_b = odd_r ? b1_r : g_rd;
    diag  = (KW'(j_r) == k_r);
    nbr   = (k_r == KW'(j_r) + KW'(1)) || (KW'(j_r) == k_r + KW'(1));
    inner = (j_r != '0) && (j_r != HW'(N - 1));
    if (diag && inner) adj = 34'(rw2_q) + 34'(rw2_q);
    else if (diag) adj = 34'(rw2_q);
    else if (nbr) adj = -34'(rw2_q);
    else adj = '0;
    // Speed check: invalid values fall back, then the floor applies.
    vin  = lmpc_pkg::q_t'(in_speed);
    vsel = (vin < 0 || vin > lmpc_pkg::SPEED_MAX) ? lmpc_pkg::SPEED_FALLBACK : vin;
    if (vsel < lmpc_pkg::Q_SPEED_FLOOR) vsel = lmpc_pkg::Q_SPEED_FLOOR;
    diff  = mv_rd - last_r[j_r];
    // Move update with clamp to the steering limit.
    upd_t = lmpc_pkg::qsub(mv_rd, qv);
    if (upd_t > sl_q) upd_t = sl_q;
    if (upd_t < -sl_q) upd_t = -sl_q;
    // Pull a move to within the rate limit of its predecessor.
    if (d_r > srl_q) rate_nv = lmpc_pkg::qadd(prev_r, srl_q);
    else if (d_r < -srl_q) rate_nv = lmpc_pkg::qsub(prev_r, srl_q);
    else rate_nv = mv_rd;
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;  ph_nxt = ph_r;  j_nxt = j_r;  k_nxt = k_r;  i_nxt = i_r;
    odd_nxt = odd_r;  rd_k_nxt = rd_k_r;  k1_nxt = k1_r;  v1_nxt = v1_r;  v2_nxt = v2_r;
    it_nxt = it_r;  out_valid_nxt = out_valid_r;
    steer_now_nxt = steer_now_r;  steer_before_nxt = steer_before_r;
    x0_nxt = x0_r;  x1_nxt = x1_r;  v_nxt = v_r;  clip_nxt = clip_r;
    dv_nxt = dv_r;  b1_nxt = b1_r;  dx_nxt = dx_r;  dg_nxt = dg_r;  rb_nxt = rb_r;
    flast_nxt = flast_r;  glast_nxt = glast_r;  s_nxt = s_r;  t1_nxt = t1_r;
    d_nxt = d_r;  prev_nxt = prev_r;  sum_nxt = sum_r;
    out_steer_nxt = out_steer_r;  out_clip_nxt = out_clip_r;
    f0_nxt = f0_r;  g_nxt = g_r;  lt_nxt = lt_r;  mv_nxt = mv_r;
    last_nxt = last_r;  mom_nxt = mom_r;  grad_nxt = grad_r;
    mreq.a = '0;  mreq.b = '0;
    hw_en = 1'b0;  hw_addr = {j_r, k_r[HW-1:0]};  hw_data = '0;
    hr_en = 1'b0;  hr_addr = {j_r, rd_k_r[HW-1:0]};

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      lmpc_pkg::S_IDLE: begin
        if (in_valid) begin
          x0_nxt    = in_lateral_error;
          x1_nxt    = in_heading_error;
          v_nxt     = vsel;
          clip_nxt  = (vin < 0 || vin > lmpc_pkg::SPEED_MAX);
          ph_nxt    = '0;
          state_nxt = lmpc_pkg::S_SETUP;
        end
      end
      // Model scalars, one product per cycle.
      lmpc_pkg::S_SETUP: begin
        ph_nxt = ph_r + 3'd1;
        case (ph_r)
          3'd0: begin mreq.a = ts_q; mreq.b = v_r; end
          3'd1: begin dv_nxt = qv; mreq.a = rw_q; mreq.b = steer_before_r; end
          3'd2: begin rb_nxt = lmpc_pkg::qdbl(qv); mreq.a = dv_r; mreq.b = iw_q; end
          3'd3: begin b1_nxt = qv; mreq.a = dv_r; mreq.b = x1_r; end
          3'd4: begin dx_nxt = qv; mreq.a = dv_r; mreq.b = b1_r; end
          default: begin
            dg_nxt    = qv;
            f0_nxt[0] = x0_r;
            g_nxt[0]  = dv_r;
            flast_nxt = x0_r;
            glast_nxt = dv_r;
            j_nxt     = HW'(1);
            state_nxt = lmpc_pkg::S_PROP;
          end
        endcase
      end
      // Free response and impulse response, one step per cycle.
      lmpc_pkg::S_PROP: begin
        flast_nxt  = lmpc_pkg::qadd(flast_r, dx_r);
        glast_nxt  = lmpc_pkg::qadd(glast_r, dg_r);
        f0_nxt[j_r] = flast_nxt;
        g_nxt[j_r]  = glast_nxt;
        if (j_r == HW'(N - 1)) begin
          j_nxt = '0;  k_nxt = '0;
          state_nxt = lmpc_pkg::S_HSTART;
        end else begin
          j_nxt = j_r + HW'(1);
        end
      end
      // First nonzero row of this Hessian entry or linear term.
      lmpc_pkg::S_HSTART: begin
        if (lin || j_r > k_r[HW-1:0]) i_nxt = j_r;
        else i_nxt = k_r[HW-1:0];
        odd_nxt   = 1'b0;
        s_nxt     = '0;
        state_nxt = lmpc_pkg::S_HMUL1;
      end
      lmpc_pkg::S_HMUL1: begin
        mreq.a = w_sel;  mreq.b = first_b;
        state_nxt = lmpc_pkg::S_HMUL2;
      end
      lmpc_pkg::S_HMUL2: begin
        mreq.a = qv;  mreq.b = second_b;
        state_nxt = lmpc_pkg::S_HACC;
      end
      lmpc_pkg::S_HACC: begin
        s_nxt = lmpc_pkg::qadd(s_r, qv);
        state_nxt = lmpc_pkg::S_HMUL1;
        if (!odd_r) begin
          odd_nxt = 1'b1;
        end else if (last_row) begin
          ph_nxt = '0;
          state_nxt = lmpc_pkg::S_HFIN;
        end else begin
          odd_nxt = 1'b0;
          i_nxt = i_r + HW'(1);
        end
      end
      // Effort weight, doubling, rate penalty, then store.
      lmpc_pkg::S_HFIN: begin
        ph_nxt = ph_r + 3'd1;
        case (ph_r)
          3'd0: if (!lin && diag) s_nxt = lmpc_pkg::qadd(s_r, ew_q);
          3'd1: s_nxt = lmpc_pkg::qdbl(s_r);
          default: begin
            state_nxt = lmpc_pkg::S_HSTART;
            if (lin) begin
              lt_nxt[j_r] = (j_r == '0) ? lmpc_pkg::qsub(s_r, rb_r) : s_r;
              k_nxt = '0;
              if (j_r == HW'(N - 1)) state_nxt = lmpc_pkg::S_GINIT;
              else j_nxt = j_r + HW'(1);
            end else begin
              hw_en   = 1'b1;
              hw_data = lmpc_pkg::sat34(34'(s_r) + adj);
              k_nxt   = k_r + KW'(1);
            end
          end
        endcase
      end
      lmpc_pkg::S_GINIT: begin
        for (int n = 0; n < N; n++) begin
          mv_nxt[n] = '0;  last_nxt[n] = '0;  mom_nxt[n] = '0;
        end
        it_nxt = '0;  j_nxt = '0;
        s_nxt = lt_r[0];  rd_k_nxt = '0;  v1_nxt = 1'b0;  v2_nxt = 1'b0;
        state_nxt = lmpc_pkg::S_GRAD;
      end
      // Gradient row: memory read, multiply, accumulate, overlapped.
      lmpc_pkg::S_GRAD: begin
        if (rd_k_r == KW'(N) && !v1_r && !v2_r) begin
          grad_nxt[j_r] = s_r;
          rd_k_nxt = '0;
          if (j_r == HW'(N - 1)) begin
            j_nxt = '0;  ph_nxt = '0;
            state_nxt = lmpc_pkg::S_UPD;
          end else begin
            j_nxt = j_r + HW'(1);
            s_nxt = lt_r[j_r + HW'(1)];
          end
        end else begin
          if (rd_k_r != KW'(N)) begin
            hr_en    = 1'b1;
            k1_nxt   = rd_k_r[HW-1:0];
            rd_k_nxt = rd_k_r + KW'(1);
            v1_nxt   = 1'b1;
          end else begin
            v1_nxt = 1'b0;
          end
          v2_nxt = v1_r;
          if (v1_r) begin mreq.a = hq_r; mreq.b = mv_rd; end
          if (v2_r) s_nxt = lmpc_pkg::qadd(s_r, qv);
        end
      end
      // Momentum and move update with clamp.
      lmpc_pkg::S_UPD: begin
        ph_nxt = ph_r + 3'd1;
        case (ph_r)
          3'd0: begin mreq.a = lmpc_pkg::Q_BETA; mreq.b = mom_r[j_r]; end
          3'd1: begin
            t1_nxt = qv;
            mreq.a = lmpc_pkg::Q_ONE_MINUS_BETA;  mreq.b = grad_r[j_r];
          end
          3'd2: mom_nxt[j_r] = lmpc_pkg::qadd(t1_r, qv);
          3'd3: begin mreq.a = lmpc_pkg::Q_ALPHA; mreq.b = mom_r[j_r]; end
          default: begin
            mv_nxt[j_r] = upd_t;
            if (j_r == '0) prev_nxt = upd_t;
            ph_nxt = '0;
            if (j_r == HW'(N - 1)) begin
              j_nxt = HW'(1);
              state_nxt = lmpc_pkg::S_RATE;
            end else begin
              j_nxt = j_r + HW'(1);
            end
          end
        endcase
      end
      // Rate limit pass, moves in order.
      lmpc_pkg::S_RATE: begin
        if (ph_r == 3'd0) begin
          d_nxt  = lmpc_pkg::qsub(mv_rd, prev_r);
          ph_nxt = 3'd1;
        end else begin
          mv_nxt[j_r] = rate_nv;
          prev_nxt = rate_nv;
          ph_nxt = '0;
          if (j_r == HW'(N - 1)) begin
            j_nxt = '0;  sum_nxt = '0;
            state_nxt = lmpc_pkg::S_NORM;
          end else begin
            j_nxt = j_r + HW'(1);
          end
        end
      end
      // Squared change against the last iterate.
      lmpc_pkg::S_NORM: begin
        if (ph_r == 3'd0) begin
          mreq.a = diff;  mreq.b = diff;
          ph_nxt = 3'd1;
        end else begin
          sum_nxt = sum_r + 64'(prod);
          last_nxt[j_r] = mv_rd;
          ph_nxt = '0;
          if (j_r == HW'(N - 1)) begin
            j_nxt = '0;
            if (sum_nxt < lmpc_pkg::Q_STOP_SQ ||
                it_r == lmpc_pkg::ITW'(lmpc_pkg::MAX_ITER - 1)) begin
              state_nxt = lmpc_pkg::S_OUT;
            end else begin
              it_nxt = it_r + lmpc_pkg::ITW'(1);
              s_nxt = lt_r[0];  rd_k_nxt = '0;  v1_nxt = 1'b0;  v2_nxt = 1'b0;
              state_nxt = lmpc_pkg::S_GRAD;
            end
          end else begin
            j_nxt = j_r + HW'(1);
          end
        end
      end
      // Hand the item to the output register once it is free.
      lmpc_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_steer_nxt    = mv_r[0][18:0];
          out_clip_nxt     = clip_r;
          steer_before_nxt = steer_now_r;
          steer_now_nxt    = mv_r[0];
          state_nxt        = lmpc_pkg::S_IDLE;
        end
      end
      default: state_nxt = lmpc_pkg::S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= lmpc_pkg::S_IDLE;
      ph_r           <= '0;
      j_r            <= '0;
      k_r            <= '0;
      i_r            <= '0;
      odd_r          <= 1'b0;
      rd_k_r         <= '0;
      k1_r           <= '0;
      v1_r           <= 1'b0;
      v2_r           <= 1'b0;
      it_r           <= '0;
      out_valid_r    <= 1'b0;
      steer_now_r    <= '0;
      steer_before_r <= '0;
    end else begin
      state_r        <= state_nxt;
      ph_r           <= ph_nxt;
      j_r            <= j_nxt;
      k_r            <= k_nxt;
      i_r            <= i_nxt;
      odd_r          <= odd_nxt;
      rd_k_r         <= rd_k_nxt;
      k1_r           <= k1_nxt;
      v1_r           <= v1_nxt;
      v2_r           <= v2_nxt;
      it_r           <= it_nxt;
      out_valid_r    <= out_valid_nxt;
      steer_now_r    <= steer_now_nxt;
      steer_before_r <= steer_before_nxt;
    end
  end

  // Payload registers and vector stores.
  always_ff @(posedge clk) begin
    x0_r <= x0_nxt;  x1_r <= x1_nxt;  v_r <= v_nxt;  clip_r <= clip_nxt;
    dv_r <= dv_nxt;  b1_r <= b1_nxt;  dx_r <= dx_nxt;  dg_r <= dg_nxt;  rb_r <= rb_nxt;
    flast_r <= flast_nxt;  glast_r <= glast_nxt;  s_r <= s_nxt;  t1_r <= t1_nxt;
    d_r <= d_nxt;  prev_r <= prev_nxt;  sum_r <= sum_nxt;
    out_steer_r <= out_steer_nxt;  out_clip_r <= out_clip_nxt;
    f0_r <= f0_nxt;  g_r <= g_nxt;  lt_r <= lt_nxt;  mv_r <= mv_nxt;
    last_r <= last_nxt;  mom_r <= mom_nxt;  grad_r <= grad_nxt;
  end

  assign in_ready           = (state_r == lmpc_pkg::S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_steering_angle = out_steer_r;
  assign out_speed_clipped  = out_clip_r;

  // An accepted item keeps the sequencer busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sequencer not busy after an accepted item");

  // A new result appears only from the output state.
  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == lmpc_pkg::S_OUT))
    else $error("result raised outside the output state");

  // The accumulate stage of the gradient pipe follows a multiply stage.
  a_grad_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lmpc_pkg::S_GRAD && v2_r) |-> $past(v1_r))
    else $error("gradient accumulate without a product");

  // Iteration count stays within the bound.
  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    it_r <= lmpc_pkg::ITW'(lmpc_pkg::MAX_ITER - 1))
    else $error("iteration counter past its bound");

endmodule
`default_nettype wire
